// ----- hdl/tsg_pkg.sv -----
`default_nettype none
package tsg_pkg;

  // Default width of every coordinate field.
  localparam int COORD_BITS_DEF = 16;

  // Codes carried in the input tuser bit.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

endpackage
`default_nettype wire

// ----- hdl/tsg_sort.sv -----
`default_nettype none
module tsg_sort #(
  parameter int W = tsg_pkg::COORD_BITS_DEF
) (
  input  logic signed [W-1:0] a_x_i,
  input  logic signed [W-1:0] a_y_i,
  input  logic signed [W-1:0] b_x_i,
  input  logic signed [W-1:0] b_y_i,
  input  logic signed [W-1:0] c_x_i,
  input  logic signed [W-1:0] c_y_i,
  output logic signed [W-1:0] top_x_o,
  output logic signed [W-1:0] top_y_o,
  output logic signed [W-1:0] mid_x_o,
  output logic signed [W-1:0] mid_y_o,
  output logic signed [W-1:0] bot_x_o,
  output logic signed [W-1:0] bot_y_o
);
  import tsg_pkg::*;

  logic signed [W-1:0] b1_x, b1_y, c1_x, c1_y;
  logic signed [W-1:0] a2_x, a2_y, b2_x, b2_y;

  // Three compare-exchange steps on y; equal keys keep their order.
  always_comb begin
    if (b_y_i > c_y_i) begin
      b1_x = c_x_i; b1_y = c_y_i; c1_x = b_x_i; c1_y = b_y_i;
    end else begin
      b1_x = b_x_i; b1_y = b_y_i; c1_x = c_x_i; c1_y = c_y_i;
    end
    if (a_y_i > b1_y) begin
      a2_x = b1_x; a2_y = b1_y; b2_x = a_x_i; b2_y = a_y_i;
    end else begin
      a2_x = a_x_i; a2_y = a_y_i; b2_x = b1_x; b2_y = b1_y;
    end
    top_x_o = a2_x;
    top_y_o = a2_y;
    if (b2_y > c1_y) begin
      mid_x_o = c1_x; mid_y_o = c1_y; bot_x_o = b2_x; bot_y_o = b2_y;
    end else begin
      mid_x_o = b2_x; mid_y_o = b2_y; bot_x_o = c1_x; bot_y_o = c1_y;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tsg_edge.sv -----
`default_nettype none
module tsg_edge #(
  parameter int W = tsg_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic signed [W-1:0] far_x_i,
  input  logic signed [W-1:0] far_y_i,
  input  logic signed [W-1:0] near_x_i,
  input  logic signed [W-1:0] near_y_i,
  input  logic signed [W-1:0] row_i,
  output logic                done_o,
  output logic signed [W-1:0] x_o
);
  import tsg_pkg::*;

  localparam int CW = $clog2(W + 1);

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_MUL  = 5'b00010,
    E_PREP = 5'b00100,
    E_DIV  = 5'b01000,
    E_FIX  = 5'b10000
  } edge_state_t;

  edge_state_t st_r, st_nxt;

  logic signed [W:0]     dr_r, dx_r, dy_r;
  logic signed [W-1:0]   fx_r;
  logic signed [2*W+1:0] prod_r;
  logic [W-1:0]          dmag_r;
  logic                  neg_r;
  logic [W-1:0]          rem_r;
  logic [W-1:0]          quo_r;
  logic [CW-1:0]         cnt_r;

  logic signed [2*W+1:0] pmag;
  logic [W:0]            rem_sh;
  logic [W:0]            diff;
  logic                  ge;
  logic [W+1:0]          qs;
  logic [W+1:0]          sum;

  // Sequencer: multiply, take magnitudes, one quotient bit a cycle, fix sign.
  // A start in the finishing cycle launches the next edge right away.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      E_IDLE: if (start_i) st_nxt = E_MUL;
      E_MUL:  st_nxt = E_PREP;
      E_PREP: st_nxt = E_DIV;
      E_DIV:  if (cnt_r == CW'(1)) st_nxt = E_FIX;
      E_FIX:  st_nxt = start_i ? E_MUL : E_IDLE;
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Restoring divide step on the magnitudes.
  always_comb begin
    pmag   = prod_r[2*W+1] ? -prod_r : prod_r;
    rem_sh = {rem_r, quo_r[W-1]};
    ge     = rem_sh >= {1'b0, dmag_r};
    diff   = rem_sh - {1'b0, dmag_r};
  end

  // Datapath registers. Operands are taken while idle and while finishing.
  always_ff @(posedge clk) begin
    case (st_r) inside
      E_IDLE, E_FIX: begin
        dr_r <= (W+1)'(row_i) - (W+1)'(far_y_i);
        dx_r <= (W+1)'(near_x_i) - (W+1)'(far_x_i);
        dy_r <= (W+1)'(near_y_i) - (W+1)'(far_y_i);
        fx_r <= far_x_i;
      end
      E_MUL: begin
        prod_r <= dr_r * dx_r;
        dmag_r <= dy_r[W] ? W'(-dy_r) : dy_r[W-1:0];
        neg_r  <= dy_r[W];
      end
      E_PREP: begin
        neg_r <= neg_r ^ prod_r[2*W+1];
        rem_r <= pmag[2*W-1:W];
        quo_r <= pmag[W-1:0];
        cnt_r <= CW'(W);
      end
      E_DIV: begin
        rem_r <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
      end
      default: ;
    endcase
  end

  // Quotient truncates toward zero, then the far vertex x is added.
  always_comb begin
    qs     = {2'b00, quo_r};
    sum    = (W+2)'(fx_r) + (neg_r ? -qs : qs);
    done_o = (st_r == E_FIX);
    x_o    = sum[W-1:0];
  end

endmodule
`default_nettype wire

// ----- hdl/triangle_scanline_span_generator.sv -----
// Load beat and advance beat with no triangle: accepted, no output beat.
// Sloped span: the single shared edge divider is run twice, one quotient bit per cycle,
// before the output beat; the next beat is accepted once the span has moved to the
// output register. Flat rows skip the divider; in_tready is low while a span is being
// worked on or waits for a full output register. Reset (sync, active low) zeroes
// vertices, row, active.
`default_nettype none
module triangle_scanline_span_generator #(
  parameter int COORD_BITS = tsg_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic [0:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // row, left_x, right_x
  output logic [((3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tlast
);
  import tsg_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EDGE1 = 4'b0010,
    S_EDGE2 = 4'b0100,
    S_EMIT  = 4'b1000
  } span_state_t;

  span_state_t st_r, st_nxt;

  logic signed [W-1:0] top_x_r, top_y_r, mid_x_r, mid_y_r, bot_x_r, bot_y_r;
  logic signed [W-1:0] row_r;
  logic                active_r;
  logic signed [W-1:0] xs_r, xe_r;
  logic                out_valid_r;
  logic signed [W-1:0] out_row_r, out_left_r, out_right_r;
  logic                out_last_r;

  logic signed [W-1:0] s_top_x, s_top_y, s_mid_x, s_mid_y, s_bot_x, s_bot_y;
  logic signed [W-1:0] min_ab, max_ab, min3, max3;
  logic signed [W-1:0] e_far_x, e_far_y, e_near_x, e_near_y, e_x;
  logic                e_start, e_done;
  logic                in_go, load_go, adv_go;
  logic                flat_all, upper, flat_top, slot_free, last_row;

  // Vertex sort for a load beat.
  tsg_sort #(.W(W)) u_sort (
    .a_x_i   ($signed(in_tdata[0*W +: W])),
    .a_y_i   ($signed(in_tdata[1*W +: W])),
    .b_x_i   ($signed(in_tdata[2*W +: W])),
    .b_y_i   ($signed(in_tdata[3*W +: W])),
    .c_x_i   ($signed(in_tdata[4*W +: W])),
    .c_y_i   ($signed(in_tdata[5*W +: W])),
    .top_x_o (s_top_x),
    .top_y_o (s_top_y),
    .mid_x_o (s_mid_x),
    .mid_y_o (s_mid_y),
    .bot_x_o (s_bot_x),
    .bot_y_o (s_bot_y)
  );

  // Beat decode and span classification.
  always_comb begin
    in_tready = (st_r == S_IDLE);
    in_go     = in_tvalid && in_tready;
    load_go   = in_go && (in_tuser[0] == OP_LOAD);
    adv_go    = in_go && (in_tuser[0] == OP_ADVANCE) && active_r;
    flat_all  = (top_y_r == bot_y_r);
    upper     = (row_r <= mid_y_r);
    flat_top  = upper && (top_y_r == mid_y_r);
    slot_free = !out_valid_r || out_tready;
    last_row  = (row_r >= bot_y_r);
    min_ab    = (top_x_r < mid_x_r) ? top_x_r : mid_x_r;
    max_ab    = (top_x_r > mid_x_r) ? top_x_r : mid_x_r;
    min3      = (bot_x_r < min_ab) ? bot_x_r : min_ab;
    max3      = (bot_x_r > max_ab) ? bot_x_r : max_ab;
  end

  // Edge operands: the short edge first, then the long top-to-bottom edge.
  always_comb begin
    e_start = (st_r == S_IDLE && adv_go && !flat_all && !flat_top) ||
              (st_r == S_EDGE1 && e_done);
    if (st_r == S_IDLE) begin
      if (upper) begin
        e_far_x = mid_x_r; e_far_y = mid_y_r; e_near_x = top_x_r; e_near_y = top_y_r;
      end else begin
        e_far_x = bot_x_r; e_far_y = bot_y_r; e_near_x = mid_x_r; e_near_y = mid_y_r;
      end
    end else begin
      e_far_x = bot_x_r; e_far_y = bot_y_r; e_near_x = top_x_r; e_near_y = top_y_r;
    end
  end

  tsg_edge #(.W(W)) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (e_start),
    .far_x_i  (e_far_x),
    .far_y_i  (e_far_y),
    .near_x_i (e_near_x),
    .near_y_i (e_near_y),
    .row_i    (row_r),
    .done_o   (e_done),
    .x_o      (e_x)
  );

  // Span sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (adv_go) st_nxt = (flat_all || flat_top) ? S_EMIT : S_EDGE1;
      end
      S_EDGE1: if (e_done) st_nxt = S_EDGE2;
      S_EDGE2: if (e_done) st_nxt = S_EMIT;
      S_EMIT:  if (slot_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control state and triangle registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      top_x_r     <= '0;
      top_y_r     <= '0;
      mid_x_r     <= '0;
      mid_y_r     <= '0;
      bot_x_r     <= '0;
      bot_y_r     <= '0;
      row_r       <= '0;
    end else begin
      st_r <= st_nxt;
      if (load_go) begin
        top_x_r  <= s_top_x;
        top_y_r  <= s_top_y;
        mid_x_r  <= s_mid_x;
        mid_y_r  <= s_mid_y;
        bot_x_r  <= s_bot_x;
        bot_y_r  <= s_bot_y;
        row_r    <= s_top_y;
        active_r <= 1'b1;
      end
      if (st_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
        if (last_row) begin
          active_r <= 1'b0;
        end else begin
          row_r <= row_r + W'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Span end points and the output register.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && adv_go) begin
      if (flat_all) begin
        xs_r <= min3;
        xe_r <= max3;
      end else begin
        xs_r <= top_x_r;
        xe_r <= mid_x_r;
      end
    end
    if (st_r == S_EDGE1 && e_done) xs_r <= e_x;
    if (st_r == S_EDGE2 && e_done) xe_r <= e_x;
    if (st_r == S_EMIT && slot_free) begin
      out_row_r   <= row_r;
      out_left_r  <= (xs_r > xe_r) ? xe_r : xs_r;
      out_right_r <= (xs_r > xe_r) ? xs_r : xe_r;
      out_last_r  <= last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_right_r, out_left_r, out_row_r});

  // A delivered span is ordered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r <= out_right_r))
    else $error("span left end beyond right end");

  // A loaded triangle stays sorted by y.
  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (top_y_r <= mid_y_r && mid_y_r <= bot_y_r))
    else $error("vertices out of y order");

  // The row never walks past the triangle.
  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (row_r >= top_y_r && row_r <= bot_y_r))
    else $error("row outside triangle");

  // Span work only runs on a loaded triangle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> active_r)
    else $error("span in progress with no triangle");

endmodule
`default_nettype wire
